### hdl/etfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etfp_pkg
// Shared types, constants and helpers for the escape-time fractal pixel core.
// ----------------------------------------------------------------------------
package etfp_pkg;

    // Fixed-point format and count width
    localparam int unsigned FRAC_BITS   = 28;
    localparam int unsigned ITER_BITS   = 16;
    localparam int unsigned MAX_COLUMNS = 4096;
    localparam int unsigned MAX_ROWS    = 4096;

    localparam logic [15:0] COL_LAST    = 16'(MAX_COLUMNS - 1);
    localparam logic [15:0] ROW_LAST    = 16'(MAX_ROWS - 1);
    localparam logic [15:0] COUNT_MASK  = 16'((64'd1 << ITER_BITS) - 64'd1);
    // |z|^2 threshold of 4.0
    localparam logic [64:0] ESCAPE_LIMIT = 65'd4 << FRAC_BITS;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_RE   = 3'd0;
    localparam logic [2:0] CFG_START_IM   = 3'd1;
    localparam logic [2:0] CFG_PIXEL_STEP = 3'd2;
    localparam logic [2:0] CFG_SEED_RE    = 3'd3;
    localparam logic [2:0] CFG_SEED_IM    = 3'd4;
    localparam logic [2:0] CFG_MAX_ITER   = 3'd5;

    typedef struct packed {
        logic signed [31:0] start_re;
        logic signed [31:0] start_im;
        logic        [30:0] pixel_step;
        logic signed [31:0] seed_re;
        logic signed [31:0] seed_im;
        logic        [15:0] max_iterations;
    } etfp_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMUL,
        ST_CADD,
        ST_SQ,
        ST_ITER,
        ST_OUT
    } etfp_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;       // latch pixel indices
        logic mul_coord;  // multipliers 0 and 1 take pixel offsets instead of z
        logic prod_en;    // capture products
        logic load_c;     // form c, load seed into z, clear count
        logic step;       // commit new z, advance count
        logic emit;       // load output register
    } etfp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic escaped;    // current z escaped after at least one update
        logic at_limit;   // count has reached the iteration limit
    } etfp_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        logic signed [31:0] r;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/escape_time_fractal_pixel_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_core
// Mandelbrot escape-time iteration for one pixel in signed Q4.28.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write registers over cfg_valid/cfg_ready with cfg_index
//   and cfg_data while the core is idle; cfg_ready is always high. Index 0
//   start_re, 1 start_im, 2 pixel_step, 3 seed_re, 4 seed_im,
//   5 max_iterations; other indexes are ignored.
//   Input: one pixel item (s_column, s_row) per s_valid/s_ready handshake.
//   Output: one item m_escape_count per pixel on m_valid/m_ready; zero means
//   the point did not escape within max_iterations.
//   Timing: one pixel at a time. Each iteration passes through ST_SQ, for
//   the three 32x32 multipliers (two shared with point set-up), then ST_ITER,
//   for the add, saturate and escape test. A pixel that never escapes is
//   iterated until its count reaches max_iterations.
//   The next pixel is accepted as soon as a result sits in the output
//   register, so a stalled receiver holds back at most one further pixel.
//   Reset: aresetn (synchronous, active low) loads the default view
//   (-2.0, +2.0), step 1049601, seed zero, limit 255, and empties the core.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [11:0] s_column,
    input  wire logic [11:0] s_row,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_escape_count
);

    etfp_pkg::etfp_cfg_t cfg;
    etfp_pkg::etfp_cmd_t cmd;
    etfp_pkg::etfp_sts_t sts;

    etfp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    etfp_datapath u_datapath (
        .aclk           (aclk),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .s_column       (s_column),
        .s_row          (s_row),
        .m_escape_count (m_escape_count)
    );

    etfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

endmodule
`default_nettype wire

### hdl/etfp_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etfp_cfg
// Configuration register file: view origin, pixel step, seed and limit.
// ----------------------------------------------------------------------------
module etfp_cfg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    output etfp_pkg::etfp_cfg_t       cfg
);

    etfp_pkg::etfp_cfg_t cfg_reg;
    etfp_pkg::etfp_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                etfp_pkg::CFG_START_RE:   cfg_next.start_re       = cfg_data;
                etfp_pkg::CFG_START_IM:   cfg_next.start_im       = cfg_data;
                etfp_pkg::CFG_PIXEL_STEP: cfg_next.pixel_step     = cfg_data[30:0];
                etfp_pkg::CFG_SEED_RE:    cfg_next.seed_re        = cfg_data;
                etfp_pkg::CFG_SEED_IM:    cfg_next.seed_im        = cfg_data;
                etfp_pkg::CFG_MAX_ITER:   cfg_next.max_iterations = cfg_data[15:0];
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_re       <= -32'sd536870912;
            cfg_reg.start_im       <= 32'sd536870912;
            cfg_reg.pixel_step     <= 31'd1049601;
            cfg_reg.seed_re        <= '0;
            cfg_reg.seed_im        <= '0;
            cfg_reg.max_iterations <= 16'd255;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

### hdl/etfp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etfp_datapath
// Point formation, shared multipliers, z update with saturation and the
// escape test.
// ----------------------------------------------------------------------------
module etfp_datapath (
    input  wire logic                 aclk,
    input  wire etfp_pkg::etfp_cfg_t  cfg,
    input  wire etfp_pkg::etfp_cmd_t  cmd,
    output etfp_pkg::etfp_sts_t       sts,
    input  wire logic [11:0]          s_column,
    input  wire logic [11:0]          s_row,
    output logic [15:0]               m_escape_count
);

    logic        [11:0] col_reg, col_next;
    logic        [11:0] row_reg, row_next;
    logic signed [63:0] prod0_reg, prod1_reg, prod2_reg;
    logic signed [31:0] c_re_reg, c_im_reg, c_re_next, c_im_next;
    logic signed [31:0] zr_reg, zi_reg, zr_next, zi_next;
    logic        [15:0] cnt_reg, cnt_next;
    logic        [15:0] count_out_reg;

    logic signed [31:0] mul_a0, mul_b0, mul_a1, mul_b1;
    logic        [63:0] sq_re, sq_im;
    logic signed [63:0] cross_sh;
    logic        [64:0] mag_sum;
    logic signed [65:0] nr_wide, ni_wide, cre_wide, cim_wide;
    logic               escaped;

    // Clamp indices that lie beyond the image
    assign col_next = ({4'b0, s_column} > etfp_pkg::COL_LAST) ?
                      etfp_pkg::COL_LAST[11:0] : s_column;
    assign row_next = ({4'b0, s_row} > etfp_pkg::ROW_LAST) ?
                      etfp_pkg::ROW_LAST[11:0] : s_row;

    // Multipliers 0 and 1 form the pixel offsets first, then z squares
    assign mul_a0 = cmd.mul_coord ? $signed({20'b0, col_reg}) : zr_reg;
    assign mul_b0 = cmd.mul_coord ? $signed({1'b0, cfg.pixel_step}) : zr_reg;
    assign mul_a1 = cmd.mul_coord ? $signed({20'b0, row_reg}) : zi_reg;
    assign mul_b1 = cmd.mul_coord ? $signed({1'b0, cfg.pixel_step}) : zi_reg;

    assign sq_re    = $unsigned(prod0_reg) >> etfp_pkg::FRAC_BITS;
    assign sq_im    = $unsigned(prod1_reg) >> etfp_pkg::FRAC_BITS;
    assign cross_sh = prod2_reg >>> (etfp_pkg::FRAC_BITS - 1);
    assign mag_sum  = {1'b0, sq_re} + {1'b0, sq_im};
    assign escaped  = (cnt_reg != 16'd0) && (mag_sum > etfp_pkg::ESCAPE_LIMIT);

    assign cre_wide = {{34{cfg.start_re[31]}}, cfg.start_re}
                    + {{2{prod0_reg[63]}}, prod0_reg};
    assign cim_wide = {{34{cfg.start_im[31]}}, cfg.start_im}
                    - {{2{prod1_reg[63]}}, prod1_reg};
    assign nr_wide  = $signed({2'b00, sq_re}) - $signed({2'b00, sq_im})
                    + {{34{c_re_reg[31]}}, c_re_reg};
    assign ni_wide  = {{2{cross_sh[63]}}, cross_sh}
                    + {{34{c_im_reg[31]}}, c_im_reg};

    always_comb begin
        c_re_next = c_re_reg;
        c_im_next = c_im_reg;
        zr_next   = zr_reg;
        zi_next   = zi_reg;
        cnt_next  = cnt_reg;
        if (cmd.load_c) begin
            c_re_next = etfp_pkg::sat32(cre_wide);
            c_im_next = etfp_pkg::sat32(cim_wide);
            zr_next   = cfg.seed_re;
            zi_next   = cfg.seed_im;
            cnt_next  = 16'd0;
        end else if (cmd.step) begin
            zr_next   = etfp_pkg::sat32(nr_wide);
            zi_next   = etfp_pkg::sat32(ni_wide);
            cnt_next  = cnt_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
        if (cmd.prod_en) begin
            prod0_reg <= mul_a0 * mul_b0;
            prod1_reg <= mul_a1 * mul_b1;
            prod2_reg <= zr_reg * zi_reg;
        end
        c_re_reg <= c_re_next;
        c_im_reg <= c_im_next;
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        cnt_reg  <= cnt_next;
        if (cmd.emit) begin
            count_out_reg <= escaped ? (cnt_reg & etfp_pkg::COUNT_MASK) : 16'd0;
        end
    end

    assign sts = '{escaped: escaped, at_limit: (cnt_reg == cfg.max_iterations)};
    assign m_escape_count = count_out_reg;

endmodule
`default_nettype wire

### hdl/etfp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etfp_ctrl
// Sequencer: point set-up, square/update iteration loop and result hand-off.
// ----------------------------------------------------------------------------
module etfp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire etfp_pkg::etfp_sts_t  sts,
    output etfp_pkg::etfp_cmd_t       cmd
);

    etfp_pkg::etfp_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  done;

    assign done = sts.escaped || sts.at_limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= etfp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            etfp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = etfp_pkg::ST_CMUL;
                end
            end
            etfp_pkg::ST_CMUL: begin
                cmd.mul_coord = 1'b1;
                cmd.prod_en   = 1'b1;
                state_next    = etfp_pkg::ST_CADD;
            end
            etfp_pkg::ST_CADD: begin
                cmd.load_c = 1'b1;
                state_next = etfp_pkg::ST_SQ;
            end
            etfp_pkg::ST_SQ: begin
                cmd.prod_en = 1'b1;
                state_next  = etfp_pkg::ST_ITER;
            end
            etfp_pkg::ST_ITER: begin
                if (done) begin
                    state_next = etfp_pkg::ST_OUT;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = etfp_pkg::ST_SQ;
                end
            end
            etfp_pkg::ST_OUT: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = etfp_pkg::ST_IDLE;
                end
            end
            default: state_next = etfp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken item");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == etfp_pkg::ST_CMUL))
        else $error("accepted item did not start point set-up");

    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (!sts.at_limit && !sts.escaped))
        else $error("iteration advanced past limit or escape");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.emit))
        else $error("result valid without a load");

endmodule
`default_nettype wire
